// ===== hdl/sodl_pkg.sv =====
// Shared types, constants and register codes for the send-on-delta sample logger.
package sodl_pkg;

  localparam int CHANNELS   = 5;
  localparam int SAMPLE_W   = 10;
  localparam int SCALED_W   = 8;
  localparam int DIVISOR_W  = 8;
  localparam int COUNT_W    = 16;
  localparam int CH_IW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DIV_STEPS  = SAMPLE_W;
  localparam int STEP_W     = $clog2(DIV_STEPS + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIVISOR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTVL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INTVL = 3'd5;

  localparam logic                 RST_ENABLE    = 1'b1;
  localparam logic [SAMPLE_W-1:0]  RST_DELTA     = 10'd2;
  localparam logic [SAMPLE_W-1:0]  RST_OFFSET    = 10'd430;
  localparam logic [DIVISOR_W-1:0] RST_DIVISOR   = 8'd1;
  localparam logic [COUNT_W-1:0]   RST_MIN_INTVL = 16'd60;
  localparam logic [COUNT_W-1:0]   RST_MAX_INTVL = 16'd600;
  localparam logic [SAMPLE_W-1:0]  RST_LAST      = 10'd255;
  localparam logic [SCALED_W-1:0]  SCALED_MAX    = 8'd255;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [SCALED_W-1:0] scaled_t;

  typedef struct packed {
    logic    second_tick;
    sample_t sample_ch0;
    sample_t sample_ch1;
    sample_t sample_ch2;
    sample_t sample_ch3;
    sample_t sample_ch4;
  } in_item_t;

  typedef struct packed {
    scaled_t scaled_ch0;
    scaled_t scaled_ch1;
    scaled_t scaled_ch2;
    scaled_t scaled_ch3;
    scaled_t scaled_ch4;
    logic    by_timeout;
  } out_item_t;

  typedef struct packed {
    logic                 enable;
    sample_t              delta_threshold;
    sample_t              offset_min;
    logic [DIVISOR_W-1:0] divisor;
    logic [COUNT_W-1:0]   min_interval;
    logic [COUNT_W-1:0]   max_interval;
  } cfg_regs_t;

endpackage

// ===== hdl/send_on_delta_sample_logger_unit.sv =====
// Top level of the send-on-delta sample logger: control sequence, sample store and output.
// Sequence: a change check over every channel (skipped when forced), then per channel a scale
// step and a wait on the bit-serial divider, and finally one output load.
// Throughput: one item per cycle without a tick or below the minimum interval; an item that
// starts a check or a record stalls the input until the sequencer is idle again; a full output waits.
// Reset is synchronous: counter cleared, last logged samples 255, registers to defaults.
module send_on_delta_sample_logger_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  sodl_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output sodl_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sodl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sodl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sodl_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_SCALE = 3'd2;
  localparam logic [2:0] ST_DIVW  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  localparam logic [CH_IW-1:0] LAST_IDX = CH_IW'(CHANNELS - 1);

  cfg_regs_t          regs;
  logic [2:0]         state;
  logic [CH_IW-1:0]   idx;
  logic               changed;
  logic               forced;
  logic [COUNT_W-1:0] seconds_count;
  logic [COUNT_W-1:0] cnt_inc;
  logic               forced_now;
  logic               below_min;
  logic               tick;
  logic               ch_hit;
  logic               out_free;

  sample_t in_samples [CHANNELS];
  sample_t samp       [CHANNELS];
  sample_t last       [CHANNELS];
  scaled_t rec        [CHANNELS];

  sample_t diff;
  sample_t dividend;
  logic    div_start;
  logic    div_done;
  scaled_t div_q;

  sodl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  sodl_serdiv u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (regs.divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_samples[0] = in_data.sample_ch0;
  assign in_samples[1] = in_data.sample_ch1;
  assign in_samples[2] = in_data.sample_ch2;
  assign in_samples[3] = in_data.sample_ch3;
  assign in_samples[4] = in_data.sample_ch4;

  // New items are taken only between records; the output register holds a finished
  // record on its own, so the next item can already be accepted while it waits.
  assign in_stall = (state != ST_IDLE);

  // Tick bookkeeping done in the cycle of acceptance.
  assign tick       = regs.enable && in_data.second_tick;
  assign cnt_inc    = seconds_count + COUNT_W'(1);
  assign forced_now = (cnt_inc >= regs.max_interval);
  assign below_min  = (cnt_inc < regs.min_interval);

  // The sample and last-logged rings rotate one channel per step, so the channel
  // under work always sits at the head of each ring.
  assign diff   = (samp[0] > last[0]) ? (samp[0] - last[0]) : (last[0] - samp[0]);
  assign ch_hit = (diff >= regs.delta_threshold);

  // Samples at or below the offset scale to zero.
  assign dividend  = (samp[0] > regs.offset_min) ? (samp[0] - regs.offset_min) : '0;
  assign div_start = (state == ST_SCALE);

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      idx           <= '0;
      changed       <= 1'b0;
      seconds_count <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        last[i] <= RST_LAST;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid && tick) begin
            seconds_count <= cnt_inc;
            idx           <= '0;
            changed       <= 1'b0;
            if (forced_now) begin
              state <= ST_SCALE;
            end else if (!below_min) begin
              state <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          for (int i = 0; i < CHANNELS - 1; i++) begin
            last[i] <= last[i+1];
          end
          last[CHANNELS-1] <= last[0];
          if (ch_hit) begin
            changed <= 1'b1;
          end
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= (changed || ch_hit) ? ST_SCALE : ST_IDLE;
          end else begin
            idx <= idx + CH_IW'(1);
          end
        end
        ST_SCALE: begin
          state <= ST_DIVW;
        end
        ST_DIVW: begin
          if (div_done) begin
            if (idx == LAST_IDX) begin
              idx   <= '0;
              state <= ST_FIN;
            end else begin
              idx   <= idx + CH_IW'(1);
              state <= ST_SCALE;
            end
          end
        end
        ST_FIN: begin
          // Commit the record: save the samples and restart the interval.
          if (out_free) begin
            seconds_count <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
              last[i] <= samp[i];
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The output register fills at the commit step and empties when the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Payload registers: sample ring, record shift register, output item.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      for (int i = 0; i < CHANNELS; i++) begin
        samp[i] <= in_samples[i];
      end
      forced <= forced_now;
    end else if (state == ST_CHECK || (state == ST_DIVW && div_done)) begin
      for (int i = 0; i < CHANNELS - 1; i++) begin
        samp[i] <= samp[i+1];
      end
      samp[CHANNELS-1] <= samp[0];
    end
    if (state == ST_DIVW && div_done) begin
      for (int i = 0; i < CHANNELS - 1; i++) begin
        rec[i] <= rec[i+1];
      end
      rec[CHANNELS-1] <= div_q;
    end
    if (state == ST_FIN && out_free) begin
      out_data.scaled_ch0 <= rec[0];
      out_data.scaled_ch1 <= rec[1];
      out_data.scaled_ch2 <= rec[2];
      out_data.scaled_ch3 <= rec[3];
      out_data.scaled_ch4 <= rec[4];
      out_data.by_timeout <= forced;
    end
  end

  // A new record appears only as the commit step of the sequencer.
  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FIN)
    else $error("output record appeared outside the commit step");

  // Committing a record restarts the seconds counter.
  a_count_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && out_free) |=> (seconds_count == '0 && out_valid))
    else $error("seconds counter not cleared on commit");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIVW)
    else $error("divider finished outside its wait step");

  // The channel pointer never runs past the last channel.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= LAST_IDX)
    else $error("channel pointer out of range");

endmodule

// ===== hdl/sodl_cfg.sv =====
// Configuration register file of the send-on-delta sample logger.
module sodl_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sodl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sodl_pkg::CFG_DATA_W-1:0] cfg_data,
  output sodl_pkg::cfg_regs_t            regs
);
  import sodl_pkg::*;

  // Writes are always accepted; cfg_ready is tied high.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.enable          <= RST_ENABLE;
      regs.delta_threshold <= RST_DELTA;
      regs.offset_min      <= RST_OFFSET;
      regs.divisor         <= RST_DIVISOR;
      regs.min_interval    <= RST_MIN_INTVL;
      regs.max_interval    <= RST_MAX_INTVL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENABLE:    regs.enable          <= cfg_data[0];
        REG_DELTA:     regs.delta_threshold <= cfg_data[SAMPLE_W-1:0];
        REG_OFFSET:    regs.offset_min      <= cfg_data[SAMPLE_W-1:0];
        REG_DIVISOR:   regs.divisor         <= cfg_data[DIVISOR_W-1:0];
        REG_MIN_INTVL: regs.min_interval    <= cfg_data[COUNT_W-1:0];
        REG_MAX_INTVL: regs.max_interval    <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/sodl_serdiv.sv =====
// Bit-serial restoring divider with clamping of the quotient to the scaled range.
module sodl_serdiv (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  sodl_pkg::sample_t              dividend,
  input  logic [sodl_pkg::DIVISOR_W-1:0]  divisor,
  output logic                           done,
  output sodl_pkg::scaled_t              quotient
);
  import sodl_pkg::*;

  logic                 busy;
  logic [STEP_W-1:0]    step;
  logic [DIVISOR_W-1:0] rem;
  sample_t              nq;       // dividend bits shift out, quotient bits shift in
  logic [DIVISOR_W-1:0] dvs;
  logic [DIVISOR_W:0]   rem_sh;
  logic [DIVISOR_W:0]   rem_sub;
  logic                 fits;

  // A zero divisor behaves as a divisor of one.
  assign dvs     = (divisor == '0) ? DIVISOR_W'(1) : divisor;
  assign rem_sh  = {rem, nq[SAMPLE_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign fits    = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      nq  <= dividend;
    end else if (busy) begin
      rem <= fits ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      nq  <= {nq[SAMPLE_W-2:0], fits};
    end
  end

  assign quotient = (nq[SAMPLE_W-1:SCALED_W] != '0) ? SCALED_MAX : nq[SCALED_W-1:0];

endmodule
